@@ design/bbp_pkg.sv @@
// Shared types, sizes and the delta-swap function of the bit permutation block.
package bbp_pkg;

   // Word and table sizes
   localparam int WIDTH      = 64;
   localparam int MAX_STAGES = 16;

   // Fixed field widths of the request, response and register
   localparam int FIELD_W = 64;
   localparam int IDX_W   = 4;
   localparam int SHIFT_W = 6;
   localparam int CNT_W   = 5;

   // Request kinds
   typedef enum logic {
      KIND_LOAD    = 1'b0,
      KIND_PERMUTE = 1'b1
   } kind_type;

   // One request as it travels down the chain of cells; a load carries its
   // mask in the data field
   typedef struct packed {
      logic               valid;
      kind_type           kind;
      logic [IDX_W-1:0]   idx;
      logic [SHIFT_W-1:0] shift;
      logic [WIDTH-1:0]   data;
   } bbp_item_type;

   // Swap bit i with bit i+d wherever bit i of m is set
   function automatic logic [WIDTH-1:0] delta_swap(input logic [WIDTH-1:0]   x,
                                                   input logic [WIDTH-1:0]   m,
                                                   input logic [SHIFT_W-1:0] d);
      logic [WIDTH-1:0] y;
      y = (x ^ (x >> d)) & m;
      if (32'(d) < WIDTH) begin
         delta_swap = x ^ y ^ (y << d);
      end else begin
         delta_swap = x;
      end
   endfunction

endpackage

@@ design/bbp_req_if.sv @@
// Request channel: stage loads and words to permute.
interface bbp_req_if import bbp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               kind;
   logic [IDX_W-1:0]   stage_index;
   logic [FIELD_W-1:0] stage_mask;
   logic [SHIFT_W-1:0] stage_shift;
   logic [FIELD_W-1:0] data_word;

   modport source (output valid, kind, stage_index, stage_mask, stage_shift, data_word,
                   input ready);
   modport sink   (input valid, kind, stage_index, stage_mask, stage_shift, data_word,
                   output ready);
endinterface

@@ design/bbp_rsp_if.sv @@
// Response channel: permuted words.
interface bbp_rsp_if import bbp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] result_word;

   modport source (output valid, result_word, input ready);
   modport sink   (input valid, result_word, output ready);
endinterface

@@ design/bbp_cell.sv @@
// One delta-swap cell: holds one table stage and one request register.
module bbp_cell import bbp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [CNT_W-1:0]   cell_id,
   input  logic [CNT_W-1:0]   stage_count,
   input  bbp_item_type       prev_item,
   output bbp_item_type       item_out
);

   bbp_item_type       item_ff;
   bbp_item_type       item_in;
   logic [WIDTH-1:0]   mask_ff;
   logic [WIDTH-1:0]   mask_in;
   logic [SHIFT_W-1:0] shift_ff;
   logic [SHIFT_W-1:0] shift_in;
   logic               load_hit;
   logic               stage_on;

   // Decode a load aimed at this cell and whether this stage is in use
   always_comb begin
      load_hit = prev_item.valid && (prev_item.kind == KIND_LOAD) &&
                 (CNT_W'(prev_item.idx) == cell_id);
      stage_on = cell_id < stage_count;
   end

   // Capture the stage on a matching load, else hold
   always_comb begin
      mask_in  = mask_ff;
      shift_in = shift_ff;
      if (load_hit) begin
         mask_in  = prev_item.data;
         shift_in = prev_item.shift;
      end
   end

   // Apply this stage to a word passing through
   always_comb begin
      item_in = prev_item;
      if (prev_item.valid && (prev_item.kind == KIND_PERMUTE) && stage_on) begin
         item_in.data = delta_swap(prev_item.data, mask_ff, shift_ff);
      end
   end

   // Advance the request and update the stage entry
   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (advance) begin
         item_ff <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mask_ff  <= mask_in;
         shift_ff <= shift_in;
      end
   end

   assign item_out = item_ff;

endmodule

@@ design/benes_bit_permutation.sv @@
// Top level of the Benes-network bit permutation block.
//
// A row of MAX_STAGES delta-swap cells, each holding one table stage, followed
// by an output register. Every request, load or permute, enters the first cell
// and moves one cell per cycle, so the block takes one request every cycle and
// a permuted word leaves from the output register after passing all MAX_STAGES
// cells. A load writes its stage when it passes the matching cell, so loads and
// permutes act in the order they were accepted. While the response is stalled
// the whole chain holds. Stages beyond csr stage_count pass words unchanged.
// Write stage_count only while no request is in flight.
module benes_bit_permutation import bbp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CNT_W-1:0] csr_wdata,
   bbp_req_if.sink          req_ch,
   bbp_rsp_if.source        rsp_ch
);

   bbp_item_type       link [MAX_STAGES+1];
   bbp_item_type       req_item;
   logic               advance;
   logic [CNT_W-1:0]   stage_count_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [WIDTH-1:0]   result_ff;

   // Move the chain whenever the output register is free or being drained
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   // Build the request entering the first cell
   always_comb begin
      req_item.valid = req_ch.valid;
      req_item.kind  = kind_type'(req_ch.kind);
      req_item.idx   = req_ch.stage_index;
      req_item.shift = req_ch.stage_shift;
      if (kind_type'(req_ch.kind) == KIND_LOAD) begin
         req_item.data = WIDTH'(req_ch.stage_mask);
      end else begin
         req_item.data = WIDTH'(req_ch.data_word);
      end
   end

   assign link[0] = req_item;

   // Chain of cells
   for (genvar i = 0; i < MAX_STAGES; i++) begin : g_cell
      bbp_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .cell_id     (CNT_W'(i)),
         .stage_count (stage_count_ff),
         .prev_item   (link[i]),
         .item_out    (link[i+1])
      );
   end

   // Hold the stage count register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_count_ff <= '0;
      end else if (csr_we) begin
         stage_count_ff <= csr_wdata;
      end
   end

   // Capture permuted words at the end of the chain; drop loads
   assign rsp_valid_in = link[MAX_STAGES].valid && (link[MAX_STAGES].kind == KIND_PERMUTE);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= link[MAX_STAGES].data;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_word = FIELD_W'(result_ff);

   // A response appears only for a permute leaving the last cell
   a_rsp_from_permute: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(rsp_valid_in))
      else $error("response raised without a permute at the chain end");

   // A load leaving the chain never produces a response
   a_load_dropped: assert property (@(posedge clock) disable iff (reset)
      (advance && link[MAX_STAGES].valid && (link[MAX_STAGES].kind == KIND_LOAD))
      |=> !rsp_valid_ff)
      else $error("load request reached the response");

   // A stalled response freezes the first cell of the chain
   a_chain_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(link[1]))
      else $error("chain moved during a response stall");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the Benes bit permutation block: stage loads, permutes, checks.
`timescale 1ns / 1ps

module tb_top;
   import bbp_pkg::*;

   localparam int SETTLE_CYCLES = 20 * (MAX_STAGES + 1);
   localparam int RAND_PHASES   = 12;
   localparam int PHASE_ITEMS   = 116;
   localparam int PRINT_LIMIT   = 40;

   typedef struct {
      kind_type           kind;
      logic [IDX_W-1:0]   idx;
      logic [FIELD_W-1:0] mask;
      logic [SHIFT_W-1:0] shift;
      logic [FIELD_W-1:0] data;
   } perm_req_type;

   logic clock;
   logic reset;
   logic             csr_we;
   logic [CNT_W-1:0] csr_wdata;

   bbp_req_if req_ch();
   bbp_rsp_if rsp_ch();

   benes_bit_permutation u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   // Mirror of the stage table and the stage count
   logic [WIDTH-1:0]   mask_tbl [MAX_STAGES];
   logic [SHIFT_W-1:0] shift_tbl [MAX_STAGES];
   logic [CNT_W-1:0]   stage_count_cfg;

   perm_req_type     pending_reqs[$];
   logic [WIDTH-1:0] expected_words[$];
   perm_req_type     in_flight_req;
   int               mismatch_count;
   int               send_idle_pct;
   int               recv_stall_pct;

   // Run the configured stages over one word
   function automatic logic [WIDTH-1:0] permute_word(input logic [WIDTH-1:0] word);
      logic [WIDTH-1:0] x;
      logic [WIDTH-1:0] y;
      int               n;
      x = word;
      n = (int'(stage_count_cfg) > MAX_STAGES) ? MAX_STAGES : int'(stage_count_cfg);
      for (int s = 0; s < n; s++) begin
         if (int'(shift_tbl[s]) < WIDTH) begin
            y = (x ^ (x >> shift_tbl[s])) & mask_tbl[s];
            x = x ^ y ^ (y << shift_tbl[s]);
         end
      end
      return x;
   endfunction

   // Apply one accepted request to the mirror: load a stage or predict a word
   task automatic track_request(input perm_req_type r);
      if (r.kind == KIND_LOAD) begin
         if (int'(r.idx) < MAX_STAGES) begin
            mask_tbl[r.idx]  = r.mask[WIDTH-1:0];
            shift_tbl[r.idx] = r.shift;
         end
      end else begin
         expected_words.push_back(permute_word(r.data[WIDTH-1:0]));
      end
   endtask

   task automatic report_mismatch(input string what, input logic [WIDTH-1:0] got,
                                  input logic [WIDTH-1:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("MISMATCH %s at %0t: got %h expected %h", what, $realtime, got, want);
      end
   endtask

   function automatic logic [FIELD_W-1:0] rand_word();
      logic [FIELD_W-1:0] a;
      logic [FIELD_W-1:0] b;
      logic [FIELD_W-1:0] c;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      c = {$urandom, $urandom};
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return FIELD_W'(1) << $urandom_range(FIELD_W - 1);
         3: return a & b & c;
         4: return a | b | c;
         default: return a;
      endcase
   endfunction

   // Favor the power-of-two distances of a real network, keep the rest reachable
   function automatic logic [SHIFT_W-1:0] rand_shift();
      case ($urandom_range(3))
         0: return SHIFT_W'(1) << $urandom_range(SHIFT_W - 1);
         1: return $urandom_range(1) ? '1 : '0;
         default: return SHIFT_W'($urandom_range(63));
      endcase
   endfunction

   function automatic perm_req_type load_req(input int idx, input logic [FIELD_W-1:0] mask,
                                             input logic [SHIFT_W-1:0] shift);
      perm_req_type r;
      r.kind  = KIND_LOAD;
      r.idx   = IDX_W'(idx);
      r.mask  = mask;
      r.shift = shift;
      r.data  = rand_word();
      return r;
   endfunction

   function automatic perm_req_type permute_req(input logic [FIELD_W-1:0] data);
      perm_req_type r;
      r.kind  = KIND_PERMUTE;
      r.idx   = IDX_W'($urandom_range(15));
      r.mask  = rand_word();
      r.shift = rand_shift();
      r.data  = data;
      return r;
   endfunction

   // Mostly permutes, a quarter reloads of random stages
   function automatic perm_req_type rand_request();
      if ($urandom_range(3) == 0) begin
         return load_req($urandom_range(MAX_STAGES - 1), rand_word(), rand_shift());
      end
      return permute_req(rand_word());
   endfunction

   // Wait until every request is accepted and every result has come back
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_reqs.size() != 0 || req_ch.valid || expected_words.size() != 0);
   endtask

   // Drain, let trailing loads leave the chain, then write the stage count
   task automatic set_stage_count(input logic [CNT_W-1:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      stage_count_cfg = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Drive requests from the pending queue, with random gaps
   always @(posedge clock) begin
      perm_req_type nxt;
      logic         launch;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            track_request(in_flight_req);
         end
         if (!req_ch.valid || req_ch.ready) begin
            launch = (pending_reqs.size() != 0) && ($urandom_range(99) >= send_idle_pct);
            if (launch) begin
               nxt = pending_reqs.pop_front();
               in_flight_req = nxt;
               req_ch.valid       <= 1'b1;
               req_ch.kind        <= nxt.kind;
               req_ch.stage_index <= nxt.idx;
               req_ch.stage_mask  <= nxt.mask;
               req_ch.stage_shift <= nxt.shift;
               req_ch.data_word   <= nxt.data;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Check each accepted result against the oldest prediction, stall at random
   always @(posedge clock) begin
      logic [WIDTH-1:0] want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected result", rsp_ch.result_word[WIDTH-1:0], 'x);
            end else begin
               want = expected_words.pop_front();
               if (rsp_ch.result_word[WIDTH-1:0] !== want) begin
                  report_mismatch("result_word", rsp_ch.result_word[WIDTH-1:0], want);
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      int send_pcts [4];
      int recv_pcts [4];
      int cnt;
      send_pcts = '{0, 83, 0, 16};
      recv_pcts = '{0, 0, 83, 16};
      mismatch_count  = 0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      stage_count_cfg = '0;
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_wdata = '0;
      req_ch.valid       = 1'b0;
      req_ch.kind        = KIND_LOAD;
      req_ch.stage_index = '0;
      req_ch.stage_mask  = '0;
      req_ch.stage_shift = '0;
      req_ch.data_word   = '0;
      rsp_ch.ready       = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Count zero after reset: permutes pass unchanged while every stage gets loaded
      pending_reqs.push_back(permute_req('0));
      pending_reqs.push_back(permute_req('1));
      pending_reqs.push_back(load_req(0, '1, SHIFT_W'(1)));
      pending_reqs.push_back(permute_req(64'hA5C3_0F96_1E78_D24B));
      pending_reqs.push_back(load_req(1, '0, '1));
      pending_reqs.push_back(load_req(2, '1, '0));
      pending_reqs.push_back(load_req(3, 64'h1, SHIFT_W'(63)));
      // Bit reversal stages
      pending_reqs.push_back(load_req(4, 64'h0000_0000_FFFF_FFFF, SHIFT_W'(32)));
      pending_reqs.push_back(load_req(5, 64'h0000_FFFF_0000_FFFF, SHIFT_W'(16)));
      pending_reqs.push_back(load_req(6, 64'h00FF_00FF_00FF_00FF, SHIFT_W'(8)));
      pending_reqs.push_back(load_req(7, 64'h0F0F_0F0F_0F0F_0F0F, SHIFT_W'(4)));
      pending_reqs.push_back(load_req(8, 64'h3333_3333_3333_3333, SHIFT_W'(2)));
      pending_reqs.push_back(load_req(9, 64'h5555_5555_5555_5555, SHIFT_W'(1)));
      for (int s = 10; s < MAX_STAGES; s++) begin
         pending_reqs.push_back(load_req(s, rand_word(), rand_shift()));
      end

      // Full chain on the extreme words, then a reload between permutes
      set_stage_count(CNT_W'(MAX_STAGES));
      pending_reqs.push_back(permute_req('0));
      pending_reqs.push_back(permute_req('1));
      pending_reqs.push_back(permute_req(64'h1));
      pending_reqs.push_back(permute_req(64'h8000_0000_0000_0000));
      pending_reqs.push_back(load_req(MAX_STAGES - 1, rand_word(), rand_shift()));
      pending_reqs.push_back(permute_req({$urandom, $urandom}));

      set_stage_count(CNT_W'(1));
      pending_reqs.push_back(permute_req({$urandom, $urandom}));

      // Count above the table saturates
      set_stage_count('1);
      pending_reqs.push_back(permute_req({$urandom, $urandom}));

      // Random phases across idling modes and stage counts; pause midway until drained
      for (int p = 0; p < RAND_PHASES; p++) begin
         case (p)
            0: cnt = MAX_STAGES;
            1: cnt = 0;
            2: cnt = 1;
            3: cnt = (1 << CNT_W) - 1;
            default: cnt = ($urandom_range(9) == 0) ? $urandom_range((1 << CNT_W) - 1)
                                                    : $urandom_range(MAX_STAGES);
         endcase
         set_stage_count(CNT_W'(cnt));
         send_idle_pct  = send_pcts[p % 4];
         recv_stall_pct = recv_pcts[p % 4];
         for (int i = 0; i < PHASE_ITEMS / 2; i++) begin
            pending_reqs.push_back(rand_request());
         end
         wait_drained();
         for (int i = PHASE_ITEMS / 2; i < PHASE_ITEMS; i++) begin
            pending_reqs.push_back(rand_request());
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Hard stop if the block hangs
   initial begin
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
